// File: src/qft_pkg.sv
// Shared constants and types for the quoted field tokenizer.
`default_nettype none

package qft_pkg;

   // field buffer geometry
   localparam int FIELD_MAX = 32;
   localparam int IDX_W     = $clog2(FIELD_MAX);
   localparam int CNT_W     = $clog2(FIELD_MAX + 1);
   // two banks of field storage share one RAM
   localparam int ADDR_W    = IDX_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] QUOTE_RESET = 8'h22;

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_QSEEN   = 2'd3
   } mode_type;

   // one field to drain from a bank
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] lim;
      logic             ovf;
      logic             split;
      logic             send_end;
   } cmd_type;

   typedef struct packed {
      logic    vld;
      cmd_type cmd;
   } push_type;

   // bank handed back by the drain side
   typedef struct packed {
      logic vld;
      logic bank;
   } rel_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       string_end;
      logic       field_truncated;
   } result_type;

endpackage

`default_nettype wire

// File: src/qft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module qft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/qft_front.sv
// Front end: accepts bytes, tracks the parse mode, fills the field banks, issues drain commands.
`default_nettype none

module qft_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic [7:0]               req_in_byte,
   input  wire logic                     req_in_last,
   input  wire logic                     csr_wr_en,
   input  wire logic [7:0]               csr_wr_data,
   output qft_pkg::push_type             push_a,
   output qft_pkg::push_type             push_b,
   input  wire qft_pkg::rel_type         rel,
   output logic                          wr_en,
   output logic [qft_pkg::ADDR_W-1:0]    wr_addr,
   output logic [7:0]                    wr_data
);
   import qft_pkg::*;

   logic [7:0]       quote_ff;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             esc_ff, esc_in;
   logic [CNT_W-1:0] lns_ff, lns_in;     // length up to the last non-space byte
   logic             wbank_ff, wbank_in;
   logic [1:0]       busy_ff;
   logic [1:0]       busy_set;
   logic             pend_vld_ff;
   logic [7:0]       pend_byte_ff;
   logic             pend_last_ff;

   logic             go;
   logic             accept;
   logic             is_q, is_sp;
   logic             e1, e2, sb, opn, do_push;
   logic [7:0]       push_val;
   cmd_type          cmd1, cmd2;

   // parse one held byte
   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      esc_in   = esc_ff;
      lns_in   = lns_ff;
      wbank_in = wbank_ff;
      e1       = 1'b0;
      e2       = 1'b0;
      sb       = 1'b0;
      opn      = 1'b0;
      do_push  = 1'b0;
      push_val = pend_byte_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      is_q     = (pend_byte_ff == quote_ff);
      is_sp    = !is_q && (pend_byte_ff == SPACE_BYTE);

      cmd1.bank     = wbank_ff;
      cmd1.lim      = cnt_ff;
      cmd1.ovf      = ovf_ff;
      cmd1.split    = 1'b0;
      cmd1.send_end = 1'b0;
      cmd2          = '0;

      unique case (mode_ff)
         MODE_BETWEEN: begin
            sb = 1'b1;
         end
         MODE_WORD: begin
            if (is_q) begin
               e1      = 1'b1;
               opn     = 1'b1;
               mode_in = MODE_QUOTED;
            end else if (is_sp) begin
               e1      = 1'b1;
               mode_in = MODE_BETWEEN;
            end else begin
               do_push = 1'b1;
            end
         end
         MODE_QUOTED: begin
            if (is_q) begin
               mode_in = MODE_QSEEN;
            end else begin
               do_push = 1'b1;
            end
         end
         MODE_QSEEN: begin
            if (is_q) begin
               // doubled quote: keep one literal quote
               do_push  = 1'b1;
               push_val = quote_ff;
               esc_in   = 1'b1;
               mode_in  = MODE_QUOTED;
            end else begin
               e1 = 1'b1;
               sb = 1'b1;
            end
         end
      endcase

      // byte seen between fields
      if (sb) begin
         if (is_q) begin
            opn     = 1'b1;
            mode_in = MODE_QUOTED;
         end else if (is_sp) begin
            mode_in = MODE_BETWEEN;
         end else begin
            opn     = 1'b1;
            mode_in = MODE_WORD;
            do_push = 1'b1;
         end
      end

      if (opn) begin
         cnt_in = '0;
         ovf_in = 1'b0;
         esc_in = 1'b0;
         lns_in = '0;
      end
      if (e1) begin
         wbank_in = !wbank_ff;
      end

      // append to the open field, drop past the buffer end
      if (do_push) begin
         if (cnt_in < CNT_W'(FIELD_MAX)) begin
            wr_en   = 1'b1;
            wr_addr = {wbank_in, cnt_in[IDX_W-1:0]};
            cnt_in  = cnt_in + 1'b1;
            if (push_val != SPACE_BYTE) begin
               lns_in = cnt_in;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end

      // end of string: close whatever is open
      if (pend_last_ff) begin
         cmd2.bank     = wbank_in;
         cmd2.lim      = cnt_in;
         cmd2.ovf      = ovf_in;
         cmd2.split    = 1'b0;
         cmd2.send_end = 1'b1;
         unique case (mode_in) inside
            MODE_WORD, MODE_QSEEN: begin
               e2 = 1'b1;
            end
            MODE_QUOTED: begin
               if (esc_in) begin
                  e2 = 1'b1;
               end else if (lns_in != '0) begin
                  // unclosed quote: split the rest on spaces
                  e2         = 1'b1;
                  cmd2.lim   = lns_in;
                  cmd2.split = 1'b1;
               end
            end
            MODE_BETWEEN: begin
            end
         endcase
         if (e1 && !e2) begin
            cmd1.send_end = 1'b1;
         end
         if (e2) begin
            wbank_in = !wbank_in;
         end
         mode_in = MODE_BETWEEN;
         cnt_in  = '0;
         ovf_in  = 1'b0;
         esc_in  = 1'b0;
         lns_in  = '0;
      end

      // write bank must be free; any close also needs the other bank free
      go = pend_vld_ff && !busy_ff[wbank_ff] && (!(e1 || e2) || !busy_ff[!wbank_ff]);

      wr_en = wr_en && go;

      push_a.vld = go && (e1 || e2);
      push_a.cmd = e1 ? cmd1 : cmd2;
      push_b.vld = go && e1 && e2;
      push_b.cmd = cmd2;

      busy_set = 2'b00;
      if (go && e1) begin
         busy_set[wbank_ff] = 1'b1;
      end
      if (go && e2) begin
         busy_set[cmd2.bank] = 1'b1;
      end
   end

   assign wr_data  = push_val;
   assign req_full = pend_vld_ff && !go;
   assign accept   = req_push && !req_full;

   // control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff    <= QUOTE_RESET;
         mode_ff     <= MODE_BETWEEN;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         esc_ff      <= 1'b0;
         lns_ff      <= '0;
         wbank_ff    <= 1'b0;
         busy_ff     <= 2'b00;
         pend_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            quote_ff <= csr_wr_data;
         end
         if (go) begin
            mode_ff  <= mode_in;
            cnt_ff   <= cnt_in;
            ovf_ff   <= ovf_in;
            esc_ff   <= esc_in;
            lns_ff   <= lns_in;
            wbank_ff <= wbank_in;
         end
         busy_ff <= (busy_ff & ~({1'b0, rel.vld} << rel.bank)) | busy_set;
         if (accept) begin
            pend_vld_ff <= 1'b1;
         end else if (go) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   // held byte
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_byte_ff <= req_in_byte;
         pend_last_ff <= req_in_last;
      end
   end

endmodule

`default_nettype wire

// File: src/qft_cmdq.sv
// Two-entry command queue between the front end and the drain side.
`default_nettype none

module qft_cmdq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qft_pkg::push_type push_a,
   input  wire qft_pkg::push_type push_b,
   input  wire logic              pop,
   output logic                   q_vld,
   output qft_pkg::cmd_type       q_cmd
);
   import qft_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   cmd_type    tmp     [2];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] cnt_mid;

   // shift on pop, then append up to two commands
   always_comb begin
      tmp[0]  = slot_ff[0];
      tmp[1]  = slot_ff[1];
      cnt_mid = cnt_ff;
      if (pop) begin
         tmp[0]  = slot_ff[1];
         cnt_mid = cnt_ff - 1'b1;
      end
      for (int k = 0; k < 2; k++) begin
         if (push_a.vld && cnt_mid == 2'(k)) begin
            slot_in[k] = push_a.cmd;
         end else if (push_b.vld && (cnt_mid + 2'(push_a.vld)) == 2'(k)) begin
            slot_in[k] = push_b.cmd;
         end else begin
            slot_in[k] = tmp[k];
         end
      end
      cnt_in = cnt_mid + 2'(push_a.vld) + 2'(push_b.vld);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign q_vld = (cnt_ff != 2'd0);
   assign q_cmd = slot_ff[0];

endmodule

`default_nettype wire

// File: src/qft_back.sv
// Drain side: reads a field bank byte by byte and queues the results.
`default_nettype none

module qft_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_vld,
   input  wire qft_pkg::cmd_type         q_cmd,
   output logic                          q_pop,
   output qft_pkg::rel_type              rel,
   output logic                          rd_en,
   output logic [qft_pkg::ADDR_W-1:0]    rd_addr,
   input  wire logic [7:0]               rd_data,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output qft_pkg::result_type           rsp_head
);
   import qft_pkg::*;

   logic             act_ff, act_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rvld_ff, rvld_in;
   logic             cur_vld_ff, cur_vld_in;
   logic [7:0]       cur_byte_ff, cur_byte_in;
   result_type       oq_ff [2];
   result_type       oq_in [2];
   logic [1:0]       ocnt_ff, ocnt_in;

   logic             adv, issue, marker, emit, done, load, opop, x_sp;
   result_type       res;

   // walk the field with one byte of lookahead for word ends
   always_comb begin
      act_in      = act_ff;
      cmd_in      = cmd_ff;
      rd_idx_in   = rd_idx_ff;
      rvld_in     = rvld_ff;
      cur_vld_in  = cur_vld_ff;
      cur_byte_in = cur_byte_ff;
      emit        = 1'b0;
      done        = 1'b0;
      res         = '0;
      x_sp        = cmd_ff.split && (rd_data == SPACE_BYTE);
      adv         = act_ff && (ocnt_ff != 2'd2);
      issue       = adv && (rd_idx_ff < cmd_ff.lim);
      marker      = !cmd_ff.split && (cmd_ff.lim == '0);
      load        = !act_ff && q_vld;

      res.field_truncated = cmd_ff.ovf;

      if (load) begin
         act_in     = 1'b1;
         cmd_in     = q_cmd;
         rd_idx_in  = '0;
         rvld_in    = 1'b0;
         cur_vld_in = 1'b0;
      end else if (adv) begin
         if (marker) begin
            // empty quoted field
            emit           = 1'b1;
            done           = 1'b1;
            res.field_end  = 1'b1;
            res.string_end = cmd_ff.send_end;
         end else begin
            rvld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (rvld_ff) begin
               if (cur_vld_ff) begin
                  emit           = 1'b1;
                  res.out_byte   = cur_byte_ff;
                  res.byte_valid = 1'b1;
                  res.field_end  = x_sp;
               end
               cur_vld_in  = !x_sp;
               cur_byte_in = rd_data;
            end else if (!issue && cur_vld_ff) begin
               // last byte of the command
               emit           = 1'b1;
               done           = 1'b1;
               res.out_byte   = cur_byte_ff;
               res.byte_valid = 1'b1;
               res.field_end  = 1'b1;
               res.string_end = cmd_ff.send_end;
               cur_vld_in     = 1'b0;
            end
         end
         if (done) begin
            act_in = 1'b0;
         end
      end
   end

   assign q_pop    = load;
   assign rel.vld  = done;
   assign rel.bank = cmd_ff.bank;
   assign rd_en    = issue;
   assign rd_addr  = {cmd_ff.bank, rd_idx_ff[IDX_W-1:0]};

   // result queue
   assign opop = rsp_pop && (ocnt_ff != 2'd0);

   always_comb begin
      oq_in[0] = oq_ff[0];
      oq_in[1] = oq_ff[1];
      ocnt_in  = ocnt_ff;
      if (opop) begin
         oq_in[0] = oq_ff[1];
         ocnt_in  = ocnt_ff - 1'b1;
      end
      if (emit) begin
         if (ocnt_in == 2'd0) begin
            oq_in[0] = res;
         end else begin
            oq_in[1] = res;
         end
         ocnt_in = ocnt_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 1'b0;
         rvld_ff    <= 1'b0;
         cur_vld_ff <= 1'b0;
         ocnt_ff    <= 2'd0;
      end else begin
         act_ff     <= act_in;
         rvld_ff    <= rvld_in;
         cur_vld_ff <= cur_vld_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rd_idx_ff   <= rd_idx_in;
      cur_byte_ff <= cur_byte_in;
      oq_ff[0]    <= oq_in[0];
      oq_ff[1]    <= oq_in[1];
   end

   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_head  = oq_ff[0];

endmodule

`default_nettype wire

// File: src/quoted_field_tokenizer.sv
// Top level of the quoted field tokenizer: front end, command queue, field RAM, drain side.
//
//   channel   direction  transaction when          payload
//   req_      in         req_push && !req_full     req_in_byte, req_in_last
//   rsp_      out        rsp_pop && !rsp_empty     rsp_out_byte, rsp_byte_valid, rsp_field_end,
//                                                  rsp_string_end, rsp_field_truncated
//   csr_      in         csr_wr_en                 csr_wr_data (quote byte)
//
// One byte per cycle is taken while a field fills and req_full is low; a closed field
// drains at up to one result per cycle after command load, first RAM read and lookahead.
// Fields fill one RAM bank while the other drains; req_full holds a byte until its
// bank, and for a closing byte the other bank too, has finished draining.
// Reset is synchronous and active high; the field RAM itself is not cleared.
// rsp_ stalls hold the drain side, which in turn holds the front end.
`default_nettype none

module quoted_field_tokenizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_field_end,
   output logic            rsp_string_end,
   output logic            rsp_field_truncated,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import qft_pkg::*;

   push_type          push_a, push_b;
   rel_type           rel;
   logic              q_vld, q_pop;
   cmd_type           q_cmd;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   result_type        rsp_head;

   qft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_a      (push_a),
      .push_b      (push_b),
      .rel         (rel),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   qft_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .push_a (push_a),
      .push_b (push_b),
      .pop    (q_pop),
      .q_vld  (q_vld),
      .q_cmd  (q_cmd)
   );

   qft_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   qft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_vld     (q_vld),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rel       (rel),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_out_byte        = rsp_head.out_byte;
   assign rsp_byte_valid      = rsp_head.byte_valid;
   assign rsp_field_end       = rsp_head.field_end;
   assign rsp_string_end      = rsp_head.string_end;
   assign rsp_field_truncated = rsp_head.field_truncated;

   // a bank being handed back can never be the one just committed
   a_rel_vs_push: assert property (@(posedge clock) disable iff (reset)
      (rel.vld && push_a.vld) |-> (rel.bank != push_a.cmd.bank))
      else $error("bank released while being committed");

   // a second command in one cycle always targets the other bank
   a_push_pair: assert property (@(posedge clock) disable iff (reset)
      push_b.vld |-> (push_a.vld && (push_a.cmd.bank != push_b.cmd.bank)))
      else $error("second command without a distinct first");

   // the empty-field marker always closes its field
   a_marker_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |-> rsp_field_end)
      else $error("empty-field marker without field end");

   // nothing is held right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("block not idle after reset");

endmodule

`default_nettype wire
